// ===== src/bitmap_shape_rasterizer_unit_defines.svh =====
// Assertion macros shared by the rasterizer RTL.
// Needs a clock named clock and a reset named reset in the including scope.
`ifndef BITMAP_SHAPE_RASTERIZER_UNIT_DEFINES_SVH
`define BITMAP_SHAPE_RASTERIZER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BSR_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rasterizer check failed");
// next-cycle implication
`define BSR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rasterizer check failed");
`else
`define BSR_ASSERT_IMPL(lbl, ante, cons)
`define BSR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== src/bsr_pkg.sv =====
// Shared types and constants of the bitmap shape rasterizer.
// No dependencies.
package bsr_pkg;

   localparam int MODE_W = 3;
   localparam int ROW_W  = 5;
   localparam int COL_W  = 6;
   localparam int SIZE_W = 6;
   localparam int SQRT_W = 6;   // radius bound per row fits the size field width

   localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_LINE   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_RECT   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_CIRCLE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_TRI    = 3'd4;
   localparam logic [MODE_W-1:0] MODE_READ   = 3'd5;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [SIZE_W-1:0] size;
      logic [SIZE_W-1:0] height;
   } req_type;

   typedef struct packed {
      logic pixel;
      logic is_read_data;
   } rsp_type;

   // ring cells of one row: a <= |col - centre| <= b
   typedef struct packed {
      logic              hit;
      logic [SQRT_W-1:0] lo;
      logic [SQRT_W-1:0] hi;
   } ring_span_type;

endpackage

// ===== src/bsr_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module bsr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                             clock,
   input  logic                             we,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
   input  logic [WIDTH-1:0]                 wdata,
   input  logic                             re,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
   output logic [WIDTH-1:0]                 rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end
endmodule

// ===== src/bsr_row_mask.sv =====
// Per-row cell mask of the current shape, one bit per column.
// Depends on bsr_pkg.
module bsr_row_mask #(
   parameter int ROWS = 32,
   parameter int COLS = 64
) (
   input  bsr_pkg::req_type       cmd,
   input  logic [$clog2(ROWS)-1:0] row_idx,
   input  bsr_pkg::ring_span_type ring,
   output logic [COLS-1:0]        mask
);
   import bsr_pkg::*;

   logic signed [9:0] y, r, c, s, h, c_end, r_hend, r_send;
   logic              span_en, span2_en, pt_en;
   logic signed [9:0] span_lo, span_hi, span2_lo, span2_hi, pt0, pt1;

   assign y      = signed'(10'(row_idx));
   assign r      = signed'(10'(cmd.row));
   assign c      = signed'(10'(cmd.col));
   assign s      = signed'(10'(cmd.size));
   assign h      = signed'(10'(cmd.height));
   assign c_end  = c + s - 10'sd1;
   assign r_hend = r + h - 10'sd1;
   assign r_send = r + s - 10'sd1;

   always_comb begin
      span_en  = 1'b0;
      span2_en = 1'b0;
      pt_en    = 1'b0;
      span_lo  = c;
      span_hi  = c_end;
      span2_lo = c;
      span2_hi = c_end;
      pt0      = c;
      pt1      = c_end;
      case (cmd.mode)
         MODE_LINE: begin
            span_en = (y == r);
         end
         MODE_RECT: begin
            span_en = (y == r) || (y == r_hend);
            pt_en   = (y >= r) && (y <= r_hend);
         end
         MODE_TRI: begin
            span_en = (y == r_send);
            pt_en   = (y >= r) && (y <= r_send);
            pt1     = c + y - r;   // diagonal
         end
         MODE_CIRCLE: begin
            span_en  = ring.hit;
            span2_en = ring.hit;
            span_lo  = c + signed'(10'(ring.lo));
            span_hi  = c + signed'(10'(ring.hi));
            span2_lo = c - signed'(10'(ring.hi));
            span2_hi = c - signed'(10'(ring.lo));
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      for (int j = 0; j < COLS; j++) begin
         mask[j] = (span_en && (10'(j) >= span_lo) && (10'(j) <= span_hi))
                || (span2_en && (10'(j) >= span2_lo) && (10'(j) <= span2_hi))
                || (pt_en && ((10'(j) == pt0) || (10'(j) == pt1)));
      end
   end
endmodule

// ===== src/bitmap_shape_rasterizer_unit.sv =====
// Bitmap shape rasterizer top: sequencer, shared squaring unit, canvas RAM.
// Depends on bsr_pkg, bsr_ram, bsr_row_mask and the assertion macro header.
// Clear and unused modes go straight to the result; read fetches one cell; draws walk
// every row, circle with one squaring multiplier (dx squared plus two 6-step roots a row).
// One transaction at a time: the next is taken once the result is in the output register.
// Reset (synchronous): empties the canvas at once through per-row valid bits.
module bitmap_shape_rasterizer_unit #(
   parameter int ROWS = 32,
   parameter int COLS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bsr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bsr_pkg::rsp_type rsp_data
);
   import bsr_pkg::*;
   `include "bitmap_shape_rasterizer_unit_defines.svh"

   localparam int RIDX_W = $clog2(ROWS);
   localparam int CIDX_W = $clog2(COLS);

   // sequencer states
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SQ   = 4'd1;  // size squared
   localparam logic [3:0] S_DX   = 4'd2;  // row offset squared
   localparam logic [3:0] S_ISH  = 4'd3;  // outer radius root
   localparam logic [3:0] S_ISL  = 4'd4;  // inner radius root
   localparam logic [3:0] S_RD   = 4'd5;  // fetch row word
   localparam logic [3:0] S_WR   = 4'd6;  // merge mask, write back
   localparam logic [3:0] S_CELL = 4'd7;  // read-cell data back
   localparam logic [3:0] S_RSP  = 4'd8;  // hand result to output register

   logic [3:0]        state_ff, state_in;
   req_type           cmd_ff, cmd_in;
   logic [RIDX_W-1:0] row_ff, row_in;
   logic [ROWS-1:0]   valid_ff, valid_in;
   logic [11:0]       sq_ff, sq_in;
   logic signed [17:0] thi_ff, thi_in, tlm_ff, tlm_in;
   logic [2:0]        bit_ff, bit_in;
   logic [SQRT_W-1:0] rhi_ff, rhi_in, rlo_ff, rlo_in;
   rsp_type           res_ff, res_in, rsp_data_ff, rsp_data_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              req_fire, rsp_free, last_row;
   logic [7:0]        mul_op;
   logic [15:0]       mul_prod;
   logic signed [17:0] prod_s, ring_lo, ring_hi;
   logic signed [9:0] dx;
   logic [7:0]        adx;
   logic [SQRT_W-1:0] cand, ring_a;
   ring_span_type     ring;
   logic [COLS-1:0]   mask, rdata, wdata;
   logic              ram_we, ram_re, cell_row_ok, cell_col_ok;
   logic [RIDX_W-1:0] ram_raddr;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign last_row  = (row_ff == RIDX_W'(ROWS - 1));

   // shared squaring unit; one product per cycle
   assign dx   = signed'(10'(row_ff)) - signed'(10'(cmd_ff.row));
   assign adx  = dx[9] ? 8'(-dx) : 8'(dx);
   assign cand = (state_ff == S_ISH ? rhi_ff : rlo_ff) | (SQRT_W'(1) << bit_ff);
   always_comb begin
      case (state_ff)
         S_SQ:    mul_op = 8'(cmd_ff.size);
         S_DX:    mul_op = adx;
         default: mul_op = 8'(cand);
      endcase
   end
   assign mul_prod = mul_op * mul_op;
   assign prod_s   = signed'(18'(mul_prod));

   // ring bounds on squared distance: s*s - s .. s*s + s
   assign ring_lo = signed'(18'(sq_ff)) - signed'(18'(cmd_ff.size));
   assign ring_hi = signed'(18'(sq_ff)) + signed'(18'(cmd_ff.size));

   // inner bound a = ceil(sqrt(lo - dx^2)), outer bound b = floor(sqrt(hi - dx^2))
   assign ring_a   = tlm_ff[17] ? '0 : rlo_ff + SQRT_W'(1);
   assign ring.lo  = ring_a;
   assign ring.hi  = rhi_ff;
   assign ring.hit = !thi_ff[17] && (ring_a <= rhi_ff);

   bsr_row_mask #(.ROWS(ROWS), .COLS(COLS)) u_mask (
      .cmd     (cmd_ff),
      .row_idx (row_ff),
      .ring    (ring),
      .mask    (mask)
   );

   // canvas storage; rows never written since the last clear read as zero
   assign cell_row_ok = (int'(req_data.row) < ROWS);
   assign ram_re      = (state_ff == S_RD) ||
                        (req_fire && (req_data.mode == MODE_READ) && cell_row_ok);
   assign ram_raddr   = (state_ff == S_IDLE) ? RIDX_W'(req_data.row) : row_ff;
   assign ram_we      = (state_ff == S_WR);
   assign wdata       = (valid_ff[row_ff] ? rdata : '0) | mask;
   assign cell_col_ok = (int'(cmd_ff.col) < COLS);

   bsr_ram #(.WIDTH(COLS), .DEPTH(ROWS)) u_canvas (
      .clock (clock),
      .we    (ram_we),
      .waddr (row_ff),
      .wdata (wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (rdata)
   );

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      row_in       = row_ff;
      valid_in     = valid_ff;
      sq_in        = sq_ff;
      thi_in       = thi_ff;
      tlm_in       = tlm_ff;
      bit_in       = bit_ff;
      rhi_in       = rhi_ff;
      rlo_in       = rlo_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd_in              = req_data;
               row_in              = '0;
               res_in.pixel        = 1'b0;
               res_in.is_read_data = (req_data.mode == MODE_READ);
               case (req_data.mode)
                  MODE_CLEAR: begin
                     valid_in = '0;
                     state_in = S_RSP;
                  end
                  MODE_LINE, MODE_RECT, MODE_TRI: state_in = S_RD;
                  MODE_CIRCLE: state_in = S_SQ;
                  MODE_READ:   state_in = S_CELL;
                  default:     state_in = S_RSP;
               endcase
            end
         end
         S_SQ: begin
            sq_in    = mul_prod[11:0];
            state_in = S_DX;
         end
         S_DX: begin
            thi_in   = ring_hi - prod_s;
            tlm_in   = ring_lo - prod_s - 18'sd1;
            rhi_in   = '0;
            bit_in   = 3'(SQRT_W - 1);
            state_in = S_ISH;
         end
         S_ISH: begin
            if (!thi_ff[17] && (prod_s <= thi_ff)) begin
               rhi_in = cand;
            end
            if (bit_ff == 3'd0) begin
               rlo_in   = '0;
               bit_in   = 3'(SQRT_W - 1);
               state_in = S_ISL;
            end else begin
               bit_in = bit_ff - 3'd1;
            end
         end
         S_ISL: begin
            if (!tlm_ff[17] && (prod_s <= tlm_ff)) begin
               rlo_in = cand;
            end
            if (bit_ff == 3'd0) begin
               state_in = S_RD;
            end else begin
               bit_in = bit_ff - 3'd1;
            end
         end
         S_RD: begin
            state_in = S_WR;
         end
         S_WR: begin
            valid_in[row_ff] = 1'b1;
            if (last_row) begin
               state_in = S_RSP;
            end else begin
               row_in   = row_ff + RIDX_W'(1);
               state_in = (cmd_ff.mode == MODE_CIRCLE) ? S_DX : S_RD;
            end
         end
         S_CELL: begin
            res_in.pixel = (int'(cmd_ff.row) < ROWS) && cell_col_ok &&
                           valid_ff[RIDX_W'(cmd_ff.row)] && rdata[CIDX_W'(cmd_ff.col)];
            state_in     = S_RSP;
         end
         S_RSP: begin
            if (rsp_free) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      row_ff      <= row_in;
      sq_ff       <= sq_in;
      thi_ff      <= thi_in;
      tlm_ff      <= tlm_in;
      bit_ff      <= bit_in;
      rhi_ff      <= rhi_in;
      rlo_ff      <= rlo_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // a clear transaction empties every row
   `BSR_ASSERT_NEXT(a_clear_empties, req_fire && (req_data.mode == MODE_CLEAR), valid_ff == '0)
   // row sweep never leaves the canvas
   `BSR_ASSERT_IMPL(a_row_in_range, state_ff == S_WR, int'(row_ff) < ROWS)
   // a read goes straight to the data-return state
   `BSR_ASSERT_NEXT(a_read_path, req_fire && (req_data.mode == MODE_READ), state_ff == S_CELL)
   // a result handed over is visible the next cycle
   `BSR_ASSERT_NEXT(a_rsp_loaded, (state_ff == S_RSP) && rsp_free, rsp_valid_ff)
endmodule

// ===== tb/bitmap_shape_rasterizer_unit_checker.sv =====
`timescale 1ns / 100ps
// Checker for the bitmap shape rasterizer: watches both channels, keeps a canvas
// of its own, predicts every result and compares it. Depends on bsr_pkg only.
module bitmap_shape_rasterizer_unit_checker #(
   parameter int ROWS = 32,
   parameter int COLS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  bsr_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  bsr_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending_count,
   output int               marked_reads
);

   import bsr_pkg::*;

   logic [COLS-1:0] canvas_copy [ROWS];
   rsp_type         pending_answers [$];
   int              fails = 0;
   int              hits  = 0;

   // clipped cell set
   function automatic void set_cell(int r, int c);
      if (r >= 0 && r < ROWS && c >= 0 && c < COLS) begin
         canvas_copy[r][c] = 1'b1;
      end
   endfunction

   // applies one command to the canvas copy, returns the answer it must give
   function automatic rsp_type raster_command(req_type cmd);
      int      r;
      int      c;
      int      s;
      int      h;
      int      lo;
      int      hi;
      int      d;
      rsp_type answer;
      r = int'(cmd.row);
      c = int'(cmd.col);
      s = int'(cmd.size);
      h = int'(cmd.height);
      answer = '0;
      case (cmd.mode)
         MODE_CLEAR: begin
            foreach (canvas_copy[i]) canvas_copy[i] = '0;
         end
         MODE_LINE: begin
            for (int i = 0; i < s; i++) set_cell(r, c + i);
         end
         MODE_RECT: begin
            for (int i = 0; i < s; i++) begin
               set_cell(r, c + i);
               set_cell(r + h - 1, c + i);
            end
            for (int i = 0; i < h; i++) begin
               set_cell(r + i, c);
               set_cell(r + i, c + s - 1);
            end
         end
         MODE_CIRCLE: begin
            lo = s * s - s;
            hi = s * s + s;
            for (int i = 0; i < ROWS; i++) begin
               for (int j = 0; j < COLS; j++) begin
                  d = (i - r) * (i - r) + (j - c) * (j - c);
                  if (d >= lo && d <= hi) set_cell(i, j);
               end
            end
         end
         MODE_TRI: begin
            for (int i = 0; i < s; i++) begin
               set_cell(r + i, c);
               set_cell(r + s - 1, c + i);
               set_cell(r + i, c + i);
            end
         end
         MODE_READ: begin
            answer.is_read_data = 1'b1;
            if (r < ROWS && c < COLS) answer.pixel = canvas_copy[r][c];
         end
         default: ;
      endcase
      return answer;
   endfunction

   task automatic report_mismatch(string msg);
      if (fails < 40) $display("[%0t] rsp mismatch: %s", $time, msg);
      fails++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (canvas_copy[i]) canvas_copy[i] = '0;
         pending_answers.delete();
      end else begin
         // result first: the block holds one transaction at a time
         if (rsp_valid && rsp_ready) begin
            if (pending_answers.size() == 0) begin
               report_mismatch("result transaction with nothing outstanding");
            end else begin
               want = pending_answers.pop_front();
               if (rsp_data.pixel !== want.pixel) begin
                  report_mismatch($sformatf("pixel got %b expected %b",
                                            rsp_data.pixel, want.pixel));
               end
               if (rsp_data.is_read_data !== want.is_read_data) begin
                  report_mismatch($sformatf("is_read_data got %b expected %b",
                                            rsp_data.is_read_data, want.is_read_data));
               end
               if (want.is_read_data && want.pixel) hits++;
            end
         end
         if (req_valid && req_ready) begin
            pending_answers.push_back(raster_command(req_data));
         end
      end
      fail_count    <= fails;
      pending_count <= pending_answers.size();
      marked_reads  <= hits;
   end

endmodule

// ===== tb/bitmap_shape_rasterizer_unit_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for bitmap_shape_rasterizer_unit: clock, reset, stimulus and verdict.
// Depends on bsr_pkg, the rasterizer RTL and bitmap_shape_rasterizer_unit_checker.
module bitmap_shape_rasterizer_unit_tb;

   import bsr_pkg::*;

   localparam int ROWS = 32;
   localparam int COLS = 64;

   // modes the block leaves unused; both must answer with an all-zero result
   localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;

   localparam int RANDOM_ITEMS = 1030;
   localparam int HOLD_AT      = 300;      // random item that triggers the long stall
   localparam int DRAIN_AT     = 700;      // random item before which the sender drains
   localparam int LONG_HOLD    = 1500;     // > circle latency, so req_ready must drop
   localparam int TAIL_CYCLES  = 600;
   localparam int CYCLE_LIMIT  = 2_000_000;

   typedef enum int { STALL_NONE, STALL_HALF, STALL_HEAVY } stall_kind_type;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_data    = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_data;

   logic    hold_request = 1'b0;   // asks the receiver for one long stall

   int      fail_count;
   int      pending_count;
   int      marked_reads;

   int      mode_sent [8];
   int      burst_left = 0;
   int      anchor_row = 0;
   int      anchor_col = 0;
   int      anchor_span = 0;

   always #4 clock = ~clock;

   bitmap_shape_rasterizer_unit #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   bitmap_shape_rasterizer_unit_checker #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) raster_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .marked_reads  (marked_reads)
   );

   function automatic req_type make_cmd(logic [MODE_W-1:0] mode, int row, int col,
                                        int size, int height);
      req_type cmd;
      cmd.mode   = mode;
      cmd.row    = ROW_W'(row);
      cmd.col    = COL_W'(col);
      cmd.size   = SIZE_W'(size);
      cmd.height = SIZE_W'(height);
      return cmd;
   endfunction

   // Mostly small extents keep shapes readable; a fifth span the whole field.
   function automatic logic [SIZE_W-1:0] pick_extent();
      if ($urandom_range(0, 4) == 0) return SIZE_W'($urandom);
      return SIZE_W'($urandom_range(0, 12));
   endfunction

   // Random command mix: about half draws, half reads. Most reads land near
   // the last shape drawn so that they see marked cells, not just zeros.
   function automatic req_type random_cmd();
      req_type cmd;
      int      pick;
      pick       = $urandom_range(0, 99);
      cmd.row    = ROW_W'($urandom);
      cmd.col    = COL_W'($urandom);
      cmd.size   = pick_extent();
      cmd.height = pick_extent();
      if (pick < 3) begin
         cmd.mode = MODE_CLEAR;
      end else if (pick < 5) begin
         cmd.mode = ($urandom_range(0, 1) != 0) ? MODE_SPARE_A : MODE_SPARE_B;
      end else if (pick < 20) begin
         cmd.mode = MODE_LINE;
      end else if (pick < 32) begin
         cmd.mode = MODE_RECT;
      end else if (pick < 40) begin
         cmd.mode = MODE_CIRCLE;
      end else if (pick < 50) begin
         cmd.mode = MODE_TRI;
      end else begin
         cmd.mode = MODE_READ;
         if ($urandom_range(0, 3) != 0) begin
            cmd.row = ROW_W'(anchor_row + $urandom_range(0, anchor_span + 2) - 2);
            cmd.col = COL_W'(anchor_col + $urandom_range(0, anchor_span + 2) - 2);
         end
      end
      if (cmd.mode inside {MODE_LINE, MODE_RECT, MODE_CIRCLE, MODE_TRI}) begin
         anchor_row  = int'(cmd.row);
         anchor_col  = int'(cmd.col);
         anchor_span = (cmd.mode == MODE_CIRCLE) ? 0 : int'(cmd.size);
      end
      return cmd;
   endfunction

   // Offers one transaction and returns at the edge that accepted it.
   // The sender works in bursts and lowers valid between them; the gap is never
   // empty, so valid is not lowered and raised in the same step.
   task automatic offer(input req_type item);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 16);
      end
      burst_left--;
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      mode_sent[item.mode]++;
   endtask

   // Sender quiet until the checker has nothing outstanding. The count is registered,
   // so the loop waits for a clock edge before it looks at the count.
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // Receiver: phases of random length with no, half or heavy stalling, plus
   // one long hold-off on request that it counts out by itself.
   initial begin
      int             run_left;
      int             hold_left;
      bit             hold_taken;
      stall_kind_type stall_kind;
      run_left   = 0;
      hold_left  = 0;
      hold_taken = 1'b0;
      stall_kind = STALL_NONE;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = LONG_HOLD - 1;
            rsp_ready <= 1'b0;
         end else begin
            if (run_left == 0) begin
               case ($urandom_range(0, 3))
                  0, 1:    stall_kind = STALL_NONE;
                  2:       stall_kind = STALL_HALF;
                  default: stall_kind = STALL_HEAVY;
               endcase
               run_left = $urandom_range(4, 80);
            end
            run_left--;
            case (stall_kind)
               STALL_NONE: rsp_ready <= 1'b1;
               STALL_HALF: rsp_ready <= ($urandom_range(0, 1) != 0);
               default:    rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Watchdog: a hung handshake ends the run here.
   initial begin
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int total;
      foreach (mode_sent[i]) mode_sent[i] = 0;

      // one reset pulse at the start, synchronous
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part ----
      offer(make_cmd(MODE_CLEAR,   0,  0,  0,  0));
      offer(make_cmd(MODE_READ,    0,  0,  0,  0));   // fresh canvas reads zero
      offer(make_cmd(MODE_LINE,    0,  0, 63,  0));   // longest line, cols 0..62
      offer(make_cmd(MODE_READ,    0, 62,  0,  0));
      offer(make_cmd(MODE_READ,    0, 63,  0,  0));   // one past the line end
      offer(make_cmd(MODE_LINE,   31, 63, 63, 63));   // clipped at the far corner
      offer(make_cmd(MODE_READ,   31, 63,  0,  0));
      offer(make_cmd(MODE_RECT,   10, 10,  0,  0));   // zero by zero draws nothing
      offer(make_cmd(MODE_RECT,   10, 20,  0,  3));   // zero width: edges at cols c and c-1
      offer(make_cmd(MODE_READ,   11, 19,  0,  0));
      offer(make_cmd(MODE_RECT,    5, 40,  4,  0));   // zero height: edges at rows r and r-1
      offer(make_cmd(MODE_READ,    4, 41,  0,  0));
      offer(make_cmd(MODE_RECT,   31, 63, 63, 63));   // largest, mostly off canvas
      offer(make_cmd(MODE_RECT,    2,  2,  8,  5));
      offer(make_cmd(MODE_READ,    6,  5,  0,  0));   // bottom edge
      offer(make_cmd(MODE_CIRCLE, 16, 32,  0,  0));   // radius zero marks the centre
      offer(make_cmd(MODE_CIRCLE, 16, 32, 63,  0));   // ring entirely off canvas
      offer(make_cmd(MODE_CIRCLE, 16, 32,  8,  0));
      offer(make_cmd(MODE_READ,   16, 40,  0,  0));   // on the ring
      offer(make_cmd(MODE_TRI,     0,  0, 63,  0));   // largest triangle, clipped
      offer(make_cmd(MODE_TRI,    20, 50,  1,  0));
      offer(make_cmd(MODE_TRI,    10, 10,  0,  0));   // zero side draws nothing
      offer(make_cmd(MODE_SPARE_A, 31, 63, 63, 63));  // unused modes, all ones
      offer(make_cmd(MODE_SPARE_B, 31, 63, 63, 63));
      offer(make_cmd(MODE_CLEAR,   0,  0,  0,  0));
      offer(make_cmd(MODE_READ,   16, 32,  0,  0));   // cleared again

      // ---- random part ----
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == HOLD_AT) hold_request <= 1'b1;   // sender keeps offering meanwhile
         if (n == DRAIN_AT) drain();
         offer(random_cmd());
      end

      // all stimulus accepted: wait out the outstanding results, then the tail
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      total = 0;
      foreach (mode_sent[i]) total += mode_sent[i];
      $display("Covered %0d transactions: %0d clear, %0d line, %0d rect, %0d circle,",
               total, mode_sent[MODE_CLEAR], mode_sent[MODE_LINE], mode_sent[MODE_RECT],
               mode_sent[MODE_CIRCLE]);
      $display("  %0d triangle, %0d read (%0d marked), %0d unused-mode; long stall and drain",
               mode_sent[MODE_TRI], mode_sent[MODE_READ], marked_reads,
               mode_sent[MODE_SPARE_A] + mode_sent[MODE_SPARE_B]);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
